### hw/rtl/stable_pivot_partition_defines.svh
// Assertion macros shared by the stable pivot partition RTL.
`ifndef STABLE_PIVOT_PARTITION_DEFINES_SVH
`define STABLE_PIVOT_PARTITION_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SPP_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define SPP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/spp_pkg.sv
// Types and constants for the stable pivot partition block.
package spp_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int GROUP_WIDTH = 2;

   localparam logic [GROUP_WIDTH-1:0] GRP_LESS    = 2'd0;
   localparam logic [GROUP_WIDTH-1:0] GRP_EQUAL   = 2'd1;
   localparam logic [GROUP_WIDTH-1:0] GRP_GREATER = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } fsm_state_type;

   typedef struct packed {
      logic                   valid;
      logic [GROUP_WIDTH-1:0] group;
      logic                   last;
   } emit_stage_type;

endpackage

### hw/rtl/stable_pivot_partition.sv
// Stable three-way partition of a value sequence around a configured pivot.
//
// Values arrive one per transfer (start high while busy is low). Each is compared
// with the pivot at arrival: smaller values are written from the bottom of a
// DEPTH-word store, greater values from the top, equal values are only counted.
// A non-final item is stored or counted and busy stays low. On the final item (flag
// set, or the item that brings the count to DEPTH) busy rises and the block reads
// the store through its single read port, one result per cycle: the smaller
// values in arrival order, the pivot once per equal value, then the greater values
// in arrival order, and no new item is taken while busy. The final transfer starts
// the emit state; each result is registered in the stage and read registers, is
// shown for one cycle on rsp_strobe and cannot be held off. The user must write
// the pivot on csr_write_enable only while idle; the block does not enforce it.
`include "stable_pivot_partition_defines.svh"

module stable_pivot_partition #(
   parameter int DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [spp_pkg::VALUE_WIDTH-1:0] req_item_value,
   input  logic                               req_item_last,
   output logic                               rsp_strobe,
   output logic signed [spp_pkg::VALUE_WIDTH-1:0] rsp_out_value,
   output logic [spp_pkg::GROUP_WIDTH-1:0]    rsp_out_group,
   output logic                               rsp_out_last,
   input  logic                               csr_write_enable,
   input  logic signed [spp_pkg::VALUE_WIDTH-1:0] csr_write_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_M1  = CW'(DEPTH - 1);

   spp_pkg::fsm_state_type state_ff, state_in;
   logic [CW-1:0] less_cnt_ff, less_cnt_in;
   logic [CW-1:0] greater_cnt_ff, greater_cnt_in;
   logic [CW-1:0] equal_cnt_ff, equal_cnt_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic signed [spp_pkg::VALUE_WIDTH-1:0] pivot_ff;
   spp_pkg::emit_stage_type stage_ff, stage_in;

   logic [CW-1:0] total_w;
   logic [CW-1:0] less_equal_w;
   logic [CW-1:0] greater_ofs_w;
   logic          accept_w;
   logic          is_less_w;
   logic          is_greater_w;
   logic          wr_en_w;
   logic [AW-1:0] wr_addr_w;
   logic [AW-1:0] rd_addr_w;
   logic [spp_pkg::VALUE_WIDTH-1:0] rd_data_w;

   assign total_w       = less_cnt_ff + greater_cnt_ff + equal_cnt_ff;
   assign less_equal_w  = less_cnt_ff + equal_cnt_ff;
   assign greater_ofs_w = DEPTH_M1 - (pos_ff - less_equal_w);
   assign busy          = (state_ff != spp_pkg::ST_IDLE);
   assign accept_w      = start && !busy;
   assign is_less_w     = (req_item_value < pivot_ff);
   assign is_greater_w  = (req_item_value > pivot_ff);

   assign wr_en_w   = accept_w && (is_less_w || is_greater_w);
   assign wr_addr_w = is_less_w ? less_cnt_ff[AW-1:0] : AW'(DEPTH_M1 - greater_cnt_ff);

   always_comb begin
      state_in       = state_ff;
      less_cnt_in    = less_cnt_ff;
      greater_cnt_in = greater_cnt_ff;
      equal_cnt_in   = equal_cnt_ff;
      pos_in         = pos_ff;
      stage_in       = '0;
      rd_addr_w      = pos_ff[AW-1:0];
      unique case (state_ff)
         spp_pkg::ST_IDLE: begin
            if (accept_w) begin
               if (is_less_w) begin
                  less_cnt_in = less_cnt_ff + CW'(1);
               end else if (is_greater_w) begin
                  greater_cnt_in = greater_cnt_ff + CW'(1);
               end else begin
                  equal_cnt_in = equal_cnt_ff + CW'(1);
               end
               pos_in = '0;
               if (req_item_last || (total_w + CW'(1) == DEPTH_CNT)) begin
                  state_in = spp_pkg::ST_EMIT;
               end
            end
         end
         spp_pkg::ST_EMIT: begin
            stage_in.valid = 1'b1;
            stage_in.last  = (pos_ff == total_w - CW'(1));
            if (pos_ff < less_cnt_ff) begin
               stage_in.group = spp_pkg::GRP_LESS;
            end else if (pos_ff < less_equal_w) begin
               stage_in.group = spp_pkg::GRP_EQUAL;
            end else begin
               stage_in.group = spp_pkg::GRP_GREATER;
               rd_addr_w      = greater_ofs_w[AW-1:0];
            end
            pos_in = pos_ff + CW'(1);
            if (stage_in.last) begin
               state_in       = spp_pkg::ST_IDLE;
               less_cnt_in    = '0;
               greater_cnt_in = '0;
               equal_cnt_in   = '0;
               pos_in         = '0;
            end
         end
         default: begin
            state_in = spp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= spp_pkg::ST_IDLE;
         less_cnt_ff    <= '0;
         greater_cnt_ff <= '0;
         equal_cnt_ff   <= '0;
         pos_ff         <= '0;
         pivot_ff       <= '0;
         stage_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         less_cnt_ff    <= less_cnt_in;
         greater_cnt_ff <= greater_cnt_in;
         equal_cnt_ff   <= equal_cnt_in;
         pos_ff         <= pos_in;
         stage_ff       <= stage_in;
         if (csr_write_enable) begin
            pivot_ff <= csr_write_data;
         end
      end
   end

   spp_ram #(
      .WIDTH(spp_pkg::VALUE_WIDTH),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en_w),
      .wr_addr(wr_addr_w),
      .wr_data(req_item_value),
      .rd_addr(rd_addr_w),
      .rd_data(rd_data_w)
   );

   assign rsp_strobe    = stage_ff.valid;
   assign rsp_out_group = stage_ff.group;
   assign rsp_out_last  = stage_ff.last;
   assign rsp_out_value = (stage_ff.group == spp_pkg::GRP_EQUAL) ? pivot_ff : rd_data_w;

   `SPP_ASSERT_SAME(a_idle_not_full, clock, reset,
      state_ff == spp_pkg::ST_IDLE, total_w < DEPTH_CNT, "store full while idle")
   `SPP_ASSERT_SAME(a_strobe_from_emit, clock, reset,
      rsp_strobe, $past(state_ff) == spp_pkg::ST_EMIT, "result without emission")
   `SPP_ASSERT_NEXT(a_last_ends_burst, clock, reset,
      rsp_strobe && rsp_out_last, !rsp_strobe, "result after last")
   `SPP_ASSERT_NEXT(a_final_starts_emit, clock, reset,
      accept_w && req_item_last, state_ff == spp_pkg::ST_EMIT,
      "final item did not start emission")

endmodule

### hw/rtl/spp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
